// ===== src/fnpa_pkg.sv =====
// package: transaction types, opcodes, status codes and register defaults for the node pool
package fnpa_pkg;

  localparam int NODES_DEFAULT = 256;

  // opcodes
  localparam logic [1:0] OP_REBUILD = 2'd0;
  localparam logic [1:0] OP_TAKE    = 2'd1;
  localparam logic [1:0] OP_RETURN  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_NODE_SIZE  = 2'd1;
  localparam logic [1:0] REG_ALIGN_LOG2 = 2'd2;
  localparam logic [1:0] REG_POOL_BASE  = 2'd3;

  // register reset values
  localparam logic [8:0]  NODE_COUNT_RST = 9'd256;
  localparam logic [15:0] NODE_SIZE_RST  = 16'd16;
  localparam logic [3:0]  ALIGN_LOG2_RST = 4'd2;
  localparam logic [31:0] POOL_BASE_RST  = 32'd0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] node_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  node_index_res;
    logic [31:0] node_address;
    logic [8:0]  free_count;
  } res_t;

  // settings the address unit needs
  typedef struct packed {
    logic [15:0] node_size;
    logic [3:0]  align_log2;
    logic [31:0] pool_base;
  } addr_cfg_t;

endpackage

// ===== src/fnpa_ram.sv =====
// generic single-write, single-read ram with registered read data
module fnpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fnpa_addr.sv =====
// node address unit: stride rounding, registered index multiply, add of base, alignment and product
module fnpa_addr
  import fnpa_pkg::*;
#(
  parameter int IW = 9
) (
  input  logic          clk,
  input  logic          load,
  input  logic [IW-1:0] idx,
  input  addr_cfg_t     cfg,
  output logic [31:0]   addr
);

  logic [16:0]    align;
  logic [16:0]    stride;
  logic [IW+16:0] prod_full;
  logic [31:0]    prod;

  always_comb begin
    align     = 17'd1 << cfg.align_log2;
    stride    = (17'(cfg.node_size) + align - 17'd1) & ~(align - 17'd1);
    prod_full = (IW+17)'(idx) * (IW+17)'(stride);
  end

  // product registered before the final add
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 32'(prod_full);
    end
  end

  assign addr = cfg.pool_base + 32'(align) + prod;

endmodule

// ===== src/fixed_node_pool_allocator_core.sv =====
// top level: free-list node pool allocator with link memory, sequencer and config registers
//
// usage
//   command channel: a transaction (cmd) is taken at a rising edge with start high
//   and busy low. one result transaction per command comes back on result, marked by
//   done for exactly one cycle; the receiver has no way to stall it.
//   config port: cfg_we writes cfg_data into register cfg_addr (0 node_count,
//   1 node_size, 2 align_log2, 3 pool_base); write only while busy is low.
// command flow
//   take, return and unused opcodes: accepted from idle into exec, which goes back
//   to idle with done; busy blocks a new command until then. the registered read of
//   the link ram (take) and the registered address multiply are both ready in exec.
//   rebuild: the link ram is written one entry a cycle, min(node_count, NODES)
//   entries, then done is raised and the block goes back to idle.
// reset
//   rst is synchronous. the free list comes up empty (head empty, count zero) and
//   the registers return to defaults. the link ram is not cleared; the list only
//   reaches entries written by a rebuild or return.
module fixed_node_pool_allocator_core
  import fnpa_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output res_t        result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  // link width holds index+1 with zero as end of list
  localparam int LW = $clog2(NODES + 1);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int XW = (LW > 9) ? LW : 9;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_BUILD = 2'd2;

  // config registers
  logic [8:0]  node_count;
  logic [15:0] node_size;
  logic [3:0]  align_log2;
  logic [31:0] pool_base;

  // control state
  logic [1:0]    state, state_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [8:0]    free_total, free_total_next;
  logic [LW-1:0] cnt, cnt_next;
  cmd_t          cmd_q;
  logic          done_next;
  res_t          result_next;

  logic          accept;
  logic [XW-1:0] lim_x;
  logic [LW-1:0] lim;
  logic [LW-1:0] head_m1;
  logic [XW-1:0] ni_x;
  logic          ni_ok;
  logic          head_empty;

  // link ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  addr_cfg_t     acfg;
  logic [31:0]   node_addr;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // effective pool size: node_count clipped to the memory depth
  assign lim_x   = (XW'(node_count) > XW'(NODES)) ? XW'(NODES) : XW'(node_count);
  assign lim     = LW'(lim_x);
  assign head_m1 = free_head - LW'(1);
  assign ni_x    = XW'(cmd_q.node_index);
  assign ni_ok   = (ni_x < lim_x);
  assign head_empty = (free_head == '0) || (XW'(free_head) > XW'(NODES));

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      node_size  <= NODE_SIZE_RST;
      align_log2 <= ALIGN_LOG2_RST;
      pool_base  <= POOL_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NODE_COUNT: node_count <= cfg_data[8:0];
        REG_NODE_SIZE:  node_size  <= cfg_data[15:0];
        REG_ALIGN_LOG2: align_log2 <= cfg_data[3:0];
        REG_POOL_BASE:  pool_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // link ram port selection: take reads at accept, return writes in exec,
  // rebuild sweeps entries in order
  always_comb begin
    ram_raddr = AW'(head_m1);
    ram_we    = 1'b0;
    ram_waddr = AW'(cnt);
    ram_wdata = cnt;
    if (state == S_BUILD) begin
      ram_we = (cnt < lim);
    end else if (state == S_EXEC && cmd_q.opcode == OP_RETURN && ni_ok) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(ni_x);
      ram_wdata = free_head;
    end
  end

  fnpa_ram #(
    .WIDTH (LW),
    .DEPTH (NODES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign acfg.node_size  = node_size;
  assign acfg.align_log2 = align_log2;
  assign acfg.pool_base  = pool_base;

  // multiply starts at accept with the head index, sum is ready in exec
  fnpa_addr #(
    .IW (LW)
  ) u_addr (
    .clk  (clk),
    .load (accept),
    .idx  (head_m1),
    .cfg  (acfg),
    .addr (node_addr)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    free_total_next = free_total;
    cnt_next        = cnt;
    done_next       = 1'b0;
    result_next     = result;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_next   = '0;
          state_next = (cmd.opcode == OP_REBUILD) ? S_BUILD : S_EXEC;
        end
      end
      S_BUILD: begin
        if (cnt < lim) begin
          cnt_next = cnt + LW'(1);
        end else begin
          // head is the highest chained node
          free_head_next             = lim;
          free_total_next            = 9'(lim_x);
          done_next                  = 1'b1;
          result_next.status         = ST_OK;
          result_next.node_index_res = '0;
          result_next.node_address   = '0;
          result_next.free_count     = 9'(lim_x);
          state_next                 = S_IDLE;
        end
      end
      S_EXEC: begin
        result_next.status         = ST_OK;
        result_next.node_index_res = '0;
        result_next.node_address   = '0;
        case (cmd_q.opcode)
          OP_TAKE: begin
            if (head_empty) begin
              result_next.status = ST_EMPTY;
            end else begin
              // pop: new head is the link read at accept
              free_head_next = ram_rdata;
              if (free_total != '0) begin
                free_total_next = free_total - 9'd1;
              end
              result_next.node_index_res = 8'(head_m1);
              result_next.node_address   = node_addr;
            end
          end
          OP_RETURN: begin
            if (!ni_ok) begin
              result_next.status = ST_RANGE;
            end else begin
              // push: the link is written in this same cycle
              free_head_next = LW'(ni_x + XW'(1));
              if (XW'(free_total) < lim_x) begin
                free_total_next = free_total + 9'd1;
              end
            end
          end
          default: ;
        endcase
        result_next.free_count = free_total_next;
        done_next              = 1'b1;
        state_next             = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      free_total <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      free_total <= free_total_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    result <= result_next;
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  // a result always closes a command and leaves the block free
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without a command in flight");

  // a take from an empty list reports empty in its result
  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_TAKE && free_head == '0)
      |=> ##1 (done && result.status == ST_EMPTY))
    else $error("take on empty list did not report empty");

  // the link ram is only written while a command is being worked on
  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("link ram written while idle");

  // a successful return leaves the returned node at the head
  a_return_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cmd_q.opcode == OP_RETURN && ni_ok)
      |=> (XW'(free_head) == $past(ni_x) + XW'(1)))
    else $error("returned node not at list head");

endmodule

// ===== verif/fixed_node_pool_allocator_checker.sv =====
// checker: predicts the node pool's results from observed commands and compares them
`timescale 1ns / 100ps

module fixed_node_pool_allocator_checker
  import fnpa_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        done,
  input  res_t        result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  // shadow registers
  logic [8:0]  node_count_q;
  logic [15:0] node_size_q;
  logic [3:0]  align_q;
  logic [31:0] base_q;

  // shadow free list: links and head stored as index + 1, zero ends the list
  logic [8:0] link_mem [NODES];
  logic [8:0] head_ptr;
  logic [8:0] free_nodes;

  res_t awaited_results[$];
  res_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    foreach (link_mem[i]) link_mem[i] = '0;
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 20) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [8:0] pool_limit();
    if (node_count_q > NODES) return 9'(NODES);
    return node_count_q;
  endfunction

  function automatic logic [31:0] node_address_of(logic [7:0] idx);
    logic [31:0] align;
    logic [31:0] stride;
    align  = 32'd1 << align_q;
    stride = ({16'd0, node_size_q} + align - 32'd1) & ~(align - 32'd1);
    return base_q + align + {24'd0, idx} * stride;
  endfunction

  // applies one command to the shadow pool and returns its result
  function automatic res_t advance_pool(cmd_t c);
    res_t       r;
    logic [8:0] lim;
    logic [7:0] idx;
    r   = '0;
    lim = pool_limit();
    case (c.opcode)
      OP_REBUILD: begin
        for (int i = 0; i < lim; i++) link_mem[i] = 9'(i);
        head_ptr   = lim;
        free_nodes = lim;
      end
      OP_TAKE: begin
        if (head_ptr == 9'd0 || head_ptr > NODES) begin
          r.status = ST_EMPTY;
        end else begin
          idx      = 8'(head_ptr - 9'd1);
          head_ptr = link_mem[idx];
          if (free_nodes > 9'd0) free_nodes--;
          r.node_index_res = idx;
          r.node_address   = node_address_of(idx);
        end
      end
      OP_RETURN: begin
        if ({1'b0, c.node_index} >= lim) begin
          r.status = ST_RANGE;
        end else begin
          link_mem[c.node_index] = head_ptr;
          head_ptr = {1'b0, c.node_index} + 9'd1;
          if (free_nodes < lim) free_nodes++;
        end
      end
      default: ;
    endcase
    r.free_count = free_nodes;
    return r;
  endfunction

  // sampled on the falling edge, where every signal is settled for the next rising edge
  always @(negedge clk) begin
    if (rst) begin
      node_count_q = NODE_COUNT_RST;
      node_size_q  = NODE_SIZE_RST;
      align_q      = ALIGN_LOG2_RST;
      base_q       = POOL_BASE_RST;
      head_ptr     = '0;
      free_nodes   = '0;
      awaited_results.delete();
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report($sformatf("result with no command outstanding: %p", result));
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (result.status !== want.status)
            report($sformatf("status %0d, want %0d", result.status, want.status));
          if (result.node_index_res !== want.node_index_res)
            report($sformatf("node index %0d, want %0d",
                             result.node_index_res, want.node_index_res));
          if (result.node_address !== want.node_address)
            report($sformatf("address %h, want %h", result.node_address, want.node_address));
          if (result.free_count !== want.free_count)
            report($sformatf("free count %0d, want %0d", result.free_count, want.free_count));
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_NODE_COUNT: node_count_q = cfg_data[8:0];
          REG_NODE_SIZE:  node_size_q  = cfg_data[15:0];
          REG_ALIGN_LOG2: align_q      = cfg_data[3:0];
          REG_POOL_BASE:  base_q       = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) awaited_results.push_back(advance_pool(cmd));
    end
    pending = awaited_results.size();
  end

endmodule

// ===== verif/fixed_node_pool_allocator_core_tb.sv =====
// testbench top: clock, reset, command and register stimulus, verdict for the node pool
`timescale 1ns / 100ps

module fixed_node_pool_allocator_core_tb;
  import fnpa_pkg::*;

  // opcode the block must treat as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 175;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  res_t        result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_NODE_COUNT;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  logic [1:0] in_flight[$];   // opcodes of accepted commands, oldest first
  logic [7:0] held[$];        // nodes handed out and not yet given back
  logic [1:0] done_op;
  logic       no_idle = 1'b0;
  int         sent_by_op[4];
  int         n_settings = 0;
  int         n_empty = 0;
  int         n_range = 0;

  fixed_node_pool_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  fixed_node_pool_allocator_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: worst case is every command a full rebuild with the longest gap after it
  initial begin
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

  // collect handed-out nodes so that most returns give back a node really in use
  always @(negedge clk) begin
    if (!rst && done && in_flight.size() > 0) begin
      done_op = in_flight.pop_front();
      if (done_op == OP_TAKE && result.status == ST_OK) held.push_back(result.node_index_res);
      if (result.status == ST_EMPTY) n_empty++;
      if (result.status == ST_RANGE) n_range++;
    end
  end

  // mostly short gaps, a few long ones; none at all in phases that run flat out
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one command transaction; start stays high when the next one follows at once
  task automatic issue(input logic [1:0] op, input logic [7:0] idx);
    int gap;
    cmd   <= '{opcode: op, node_index: idx};
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    in_flight.push_back(op);
    sent_by_op[op]++;
    if (op == OP_REBUILD) held.delete();
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and let every outstanding result come back before touching registers
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all four registers back to back, one per cycle
  task automatic write_regs(input logic [8:0] count, input logic [15:0] size,
                            input logic [3:0] align, input logic [31:0] base);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_NODE_COUNT;
    cfg_data <= {23'd0, count};
    @(posedge clk);
    cfg_addr <= REG_NODE_SIZE;
    cfg_data <= {16'd0, size};
    @(posedge clk);
    cfg_addr <= REG_ALIGN_LOG2;
    cfg_data <= {28'd0, align};
    @(posedge clk);
    cfg_addr <= REG_POOL_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // random register setting, weighted toward small pools so rebuilds stay cheap
  task automatic random_setting();
    logic [8:0]  count;
    logic [15:0] size;
    logic [3:0]  align;
    logic [31:0] base;
    case ($urandom_range(0, 9))
      0:       count = 9'd0;
      1:       count = 9'd1;
      2:       count = 9'd256;
      3:       count = 9'($urandom_range(257, 511));
      4, 5, 6: count = 9'($urandom_range(2, 16));
      default: count = 9'($urandom_range(17, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       size = 16'd1;
      1:       size = 16'hffff;
      default: size = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       align = 4'd0;
      1:       align = 4'd12;
      default: align = 4'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 3))
      0:       base = 32'd0;
      1:       base = 32'hffff_ffff;
      default: base = $urandom;
    endcase
    write_regs(count, size, align, base);
  endtask

  initial begin
    int r;
    int k;
    logic [7:0] back;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: 256 nodes of 16 bytes, 4-byte alignment, base 0
    issue(OP_TAKE, 8'h00);        // empty pool straight out of reset
    issue(OP_RETURN, 8'h05);      // return onto an empty list
    issue(OP_TAKE, 8'hff);        // gets node 5 back
    issue(OP_UNUSED, 8'hff);      // no-op, keeps the count
    issue(OP_REBUILD, 8'h00);     // full pool
    issue(OP_TAKE, 8'h00);        // highest node first
    issue(OP_TAKE, 8'h00);
    issue(OP_RETURN, 8'hff);
    issue(OP_RETURN, 8'hff);      // double free, count climbs to the pool size
    issue(OP_RETURN, 8'h00);

    // one node, widest size and 4096-byte alignment, base at the top of memory so addresses wrap
    settle();
    write_regs(9'd1, 16'hffff, 4'd12, 32'hffff_ffff);
    issue(OP_REBUILD, 8'h00);
    issue(OP_TAKE, 8'h00);
    issue(OP_TAKE, 8'h00);        // empty
    issue(OP_RETURN, 8'h01);      // index at the bound is rejected
    issue(OP_RETURN, 8'h00);
    issue(OP_RETURN, 8'h00);      // double free loops the node onto itself
    issue(OP_TAKE, 8'h00);
    issue(OP_TAKE, 8'h00);        // list not empty while the count is already zero
    issue(OP_RETURN, 8'hff);

    // count above the pool clamps to the pool size, size 1 and smallest alignment
    settle();
    write_regs(9'd511, 16'd1, 4'd0, 32'd0);
    issue(OP_REBUILD, 8'h00);
    issue(OP_TAKE, 8'h00);
    issue(OP_RETURN, 8'hff);

    // zero-node pool: everything empty or out of range
    settle();
    write_regs(9'd0, 16'd16, 4'd2, 32'd0);
    issue(OP_REBUILD, 8'h00);
    issue(OP_TAKE, 8'h00);
    issue(OP_RETURN, 8'h00);

    // random phases: mostly take/give-back traffic on a rebuilt pool, plus noise
    for (int p = 0; p < PHASES; p++) begin
      settle();
      random_setting();
      no_idle = (p % 4 == 1);
      issue(OP_REBUILD, 8'($urandom));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 42) begin
          issue(OP_TAKE, 8'($urandom));
        end else if (r < 80 && held.size() > 0) begin
          k    = $urandom_range(0, held.size() - 1);
          back = held[k];
          held.delete(k);
          issue(OP_RETURN, back);
        end else if (r < 90) begin
          // random index: out of range or double free most of the time
          issue(OP_RETURN, 8'($urandom));
        end else if (r < 95) begin
          issue(OP_REBUILD, 8'($urandom));
        end else begin
          issue(OP_UNUSED, 8'($urandom));
        end
      end
    end

    // drain, then keep the clock running to catch any stray result
    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d commands: rebuild %0d, take %0d, return %0d, no-op %0d, %0d settings",
             sent_by_op[OP_REBUILD] + sent_by_op[OP_TAKE] + sent_by_op[OP_RETURN]
             + sent_by_op[OP_UNUSED], sent_by_op[OP_REBUILD], sent_by_op[OP_TAKE],
             sent_by_op[OP_RETURN], sent_by_op[OP_UNUSED], n_settings);
    $display("%0d results checked, %0d empty takes, %0d rejected returns, %0d mismatches",
             checked, n_empty, n_range, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fnpa_pkg.sv
src/fnpa_ram.sv
src/fnpa_addr.sv
src/fixed_node_pool_allocator_core.sv
verif/fixed_node_pool_allocator_checker.sv
verif/fixed_node_pool_allocator_core_tb.sv
